// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL modules of the stack manager.
// Each macro expects clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLK(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

`define ASSERT_NEVER(name, expr, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

// File: hw/rtl/lmsm_pkg.sv
`timescale 1ns / 1ps

package lmsm_pkg;

	localparam int MAX_IDS = 1024;

	localparam logic [2:0] OP_PUSH  = 3'd0;
	localparam logic [2:0] OP_POP   = 3'd1;
	localparam logic [2:0] OP_TOP   = 3'd2;
	localparam logic [2:0] OP_PUT   = 3'd3;
	localparam logic [2:0] OP_CLEAR = 3'd4;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [2:0]         operation;
		logic [9:0]         stack_id;
		logic [9:0]         source_stack;
		logic signed [31:0] value;
	} cmd_t;

	typedef struct packed {
		logic signed [31:0] top_value;
		logic [1:0]         status;
	} rsp_t;

	typedef enum logic [2:0] {
		OPK_PUSH,
		OPK_POP,
		OPK_TOP,
		OPK_PUT,
		OPK_CLEAR,
		OPK_NOP
	} opk_t;

	typedef struct packed {
		opk_t        kind;
		logic        sid_ok;
		logic        src_ok;
		logic        same;
		logic [9:0]  sid;
		logic [9:0]  src;
		logic [31:0] value;
	} work_t;

	typedef struct packed {
		logic  valid;
		work_t item;
	} q_if_t;

	typedef enum logic [2:0] {
		BK_SWEEP,
		BK_IDLE,
		BK_EXEC,
		BK_POP,
		BK_TOP,
		BK_PUT
	} back_state_t;

endpackage

// File: hw/rtl/lmsm_front.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lmsm_front #(
	parameter int NUM_STACKS = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  lmsm_pkg::cmd_t      cmd,
	output logic                busy,
	input  logic                deq,
	input  logic                sweeping,
	output lmsm_pkg::q_if_t     q
);
	import lmsm_pkg::*;

	localparam logic [16:0] NS_LIM = 17'(NUM_STACKS);

	work_t      ent_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	logic       enq;
	work_t      cls;

	always_comb begin
		cls.sid_ok = 17'(cmd.stack_id) < NS_LIM;
		cls.src_ok = 17'(cmd.source_stack) < NS_LIM;
		cls.same   = cmd.stack_id == cmd.source_stack;
		cls.sid    = cmd.stack_id;
		cls.src    = cmd.source_stack;
		cls.value  = cmd.value;
		unique case (cmd.operation)
			OP_PUSH:  cls.kind = OPK_PUSH;
			OP_POP:   cls.kind = OPK_POP;
			OP_TOP:   cls.kind = OPK_TOP;
			OP_PUT:   cls.kind = OPK_PUT;
			OP_CLEAR: cls.kind = OPK_CLEAR;
			default:  cls.kind = OPK_NOP;
		endcase
	end

	assign busy    = (cnt_q == 2'd2) || sweeping;
	assign enq     = start && !busy;
	assign q.valid = cnt_q != 2'd0;
	assign q.item  = ent_q[rp_q];

	always_ff @(posedge clk) begin
		if (enq) begin
			ent_q[wp_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (enq) begin
				wp_q <= !wp_q;
			end
			if (deq) begin
				rp_q <= !rp_q;
			end
			if (enq && !deq) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (deq && !enq) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	`ASSERT_NEVER(a_no_overflow, enq && cnt_q == 2'd2, "Item queue overflow.")
	`ASSERT_NEVER(a_no_underflow, deq && cnt_q == 2'd0, "Item queue underflow.")
	`ASSERT_CLK(a_cnt_step, (enq && !deq) |=> cnt_q == $past(cnt_q) + 2'd1, "Queue count slip.")

endmodule

// File: hw/rtl/lmsm_back.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lmsm_back #(
	parameter int NUM_STACKS  = 1024,
	parameter int POOL_DEPTH  = 65536,
	parameter int VALUE_WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  lmsm_pkg::q_if_t  q,
	output logic             deq,
	output logic             sweeping,
	output logic             done,
	output lmsm_pkg::rsp_t   result
);
	import lmsm_pkg::*;

	localparam int STK_DEPTH = (NUM_STACKS < MAX_IDS) ? NUM_STACKS : MAX_IDS;
	localparam int SID_W     = $clog2(STK_DEPTH);
	localparam int PTR_W     = $clog2(POOL_DEPTH + 1);
	localparam int ADDR_W    = $clog2(POOL_DEPTH);
	localparam int ENT_W     = 1 + 2 * PTR_W;
	localparam logic [PTR_W-1:0] NULL_P     = PTR_W'(POOL_DEPTH);
	localparam logic [SID_W-1:0] SWEEP_LAST = SID_W'(STK_DEPTH - 1);
	localparam logic [ENT_W-1:0] EMPTY_ENT  = {1'b0, NULL_P, NULL_P};

	logic [ENT_W-1:0]       stk_mem [STK_DEPTH];
	logic [VALUE_WIDTH-1:0] val_mem [POOL_DEPTH];
	logic [PTR_W-1:0]       lnk_mem [POOL_DEPTH];

	back_state_t            state_q, state_d;
	work_t                  cur_q;
	logic [ENT_W-1:0]       ent_a_q, ent_b_q;
	logic [PTR_W-1:0]       lnk_rd_q;
	logic [VALUE_WIDTH-1:0] val_rd_q;
	logic [PTR_W-1:0]       next_free_q;
	logic [SID_W-1:0]       sweep_q;
	logic                   done_q, done_d;
	rsp_t                   rsp_q, rsp_d;

	logic                   stk_we;
	logic [SID_W-1:0]       stk_wa;
	logic [ENT_W-1:0]       stk_wd;
	logic                   nv_we, nl_we, node_re, alloc, free_clr;
	logic [ADDR_W-1:0]      nl_wa;
	logic [PTR_W-1:0]       nl_wd;

	logic                   a_ne, b_ne, full, sid_live, put_live;
	logic [PTR_W-1:0]       a_head, a_tail, b_head, b_tail;
	logic [SID_W-1:0]       sid_idx, src_idx;

	assign a_ne     = ent_a_q[ENT_W-1];
	assign a_head   = ent_a_q[2*PTR_W-1:PTR_W];
	assign a_tail   = ent_a_q[PTR_W-1:0];
	assign b_ne     = ent_b_q[ENT_W-1];
	assign b_head   = ent_b_q[2*PTR_W-1:PTR_W];
	assign b_tail   = ent_b_q[PTR_W-1:0];
	assign sid_idx  = cur_q.sid[SID_W-1:0];
	assign src_idx  = cur_q.src[SID_W-1:0];
	assign full     = next_free_q >= NULL_P;
	assign sid_live = cur_q.sid_ok && a_ne;
	assign put_live = cur_q.sid_ok && cur_q.src_ok && !cur_q.same && b_ne;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_SWEEP: begin
				if (sweep_q == SWEEP_LAST) begin
					state_d = BK_IDLE;
				end
			end
			BK_IDLE: begin
				if (q.valid) begin
					state_d = BK_EXEC;
				end
			end
			BK_EXEC: begin
				state_d = BK_IDLE;
				case (cur_q.kind)
					OPK_POP:   if (sid_live) state_d = BK_POP;
					OPK_TOP:   if (sid_live) state_d = BK_TOP;
					OPK_PUT:   if (put_live) state_d = BK_PUT;
					OPK_CLEAR: state_d = BK_SWEEP;
					default:   state_d = BK_IDLE;
				endcase
			end
			BK_POP, BK_TOP, BK_PUT: state_d = BK_IDLE;
			default: state_d = BK_SWEEP;
		endcase
	end

	always_comb begin
		deq      = 1'b0;
		stk_we   = 1'b0;
		stk_wa   = sid_idx;
		stk_wd   = EMPTY_ENT;
		nv_we    = 1'b0;
		nl_we    = 1'b0;
		nl_wa    = next_free_q[ADDR_W-1:0];
		nl_wd    = NULL_P;
		node_re  = 1'b0;
		alloc    = 1'b0;
		free_clr = 1'b0;
		done_d   = 1'b0;
		rsp_d    = '0;
		unique case (state_q)
			BK_SWEEP: begin
				stk_we = 1'b1;
				stk_wa = sweep_q;
			end
			BK_IDLE: begin
				deq = q.valid;
			end
			BK_EXEC: begin
				case (cur_q.kind)
					OPK_PUSH: begin
						done_d = 1'b1;
						if (cur_q.sid_ok) begin
							if (full) begin
								rsp_d.status = ST_FULL;
							end else begin
								nv_we  = 1'b1;
								nl_we  = 1'b1;
								nl_wd  = a_ne ? a_head : NULL_P;
								stk_we = 1'b1;
								stk_wd = {1'b1, next_free_q, a_ne ? a_tail : next_free_q};
								alloc  = 1'b1;
							end
						end
					end
					OPK_POP: begin
						if (sid_live) begin
							node_re = 1'b1;
						end else begin
							done_d = 1'b1;
						end
					end
					OPK_TOP: begin
						if (sid_live) begin
							node_re = 1'b1;
						end else begin
							done_d       = 1'b1;
							rsp_d.status = ST_EMPTY;
						end
					end
					OPK_PUT: begin
						if (put_live) begin
							stk_we = 1'b1;
							stk_wd = {1'b1, b_head, a_ne ? a_tail : b_tail};
							if (a_ne) begin
								nl_we = 1'b1;
								nl_wa = b_tail[ADDR_W-1:0];
								nl_wd = a_head;
							end
						end else begin
							done_d = 1'b1;
						end
					end
					OPK_CLEAR: begin
						done_d   = 1'b1;
						free_clr = 1'b1;
					end
					default: done_d = 1'b1;
				endcase
			end
			BK_POP: begin
				done_d = 1'b1;
				stk_we = 1'b1;
				stk_wd = (lnk_rd_q < NULL_P) ? {1'b1, lnk_rd_q, a_tail} : EMPTY_ENT;
			end
			BK_TOP: begin
				done_d          = 1'b1;
				rsp_d.top_value = 32'($signed(val_rd_q));
			end
			BK_PUT: begin
				done_d = 1'b1;
				stk_we = 1'b1;
				stk_wa = src_idx;
			end
			default: done_d = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (stk_we) begin
			stk_mem[stk_wa] <= stk_wd;
		end
		if (deq) begin
			ent_a_q <= stk_mem[q.item.sid[SID_W-1:0]];
			ent_b_q <= stk_mem[q.item.src[SID_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (nv_we) begin
			val_mem[next_free_q[ADDR_W-1:0]] <= VALUE_WIDTH'(cur_q.value);
		end
		if (node_re) begin
			val_rd_q <= val_mem[a_head[ADDR_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (nl_we) begin
			lnk_mem[nl_wa] <= nl_wd;
		end
		if (node_re) begin
			lnk_rd_q <= lnk_mem[a_head[ADDR_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (deq) begin
			cur_q <= q.item;
		end
		rsp_q <= rsp_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_SWEEP;
			sweep_q     <= '0;
			next_free_q <= '0;
			done_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			sweep_q <= (state_q == BK_SWEEP) ? sweep_q + 1'b1 : '0;
			if (free_clr) begin
				next_free_q <= '0;
			end else if (alloc) begin
				next_free_q <= next_free_q + 1'b1;
			end
			done_q <= done_d;
		end
	end

	assign sweeping = state_q == BK_SWEEP;
	assign done     = done_q;
	assign result   = rsp_q;

	`ASSERT_CLK(a_done_src, done_q |-> ($past(state_q) == BK_EXEC || $past(state_q) == BK_POP || $past(state_q) == BK_TOP || $past(state_q) == BK_PUT), "Result strobe from a wrong state.")
	`ASSERT_NEVER(a_free_bound, next_free_q > NULL_P, "Allocator ran past the pool.")
	`ASSERT_CLK(a_exec_after_idle, state_q == BK_EXEC |-> $past(state_q) == BK_IDLE, "Execute without a fetched item.")

endmodule

// File: hw/rtl/linked_multi_stack_manager_unit.sv
`timescale 1ns / 1ps

// Many stacks kept as linked lists in one shared node pool. An item is accepted when start is
// high and busy is low; every item gives exactly one result, shown on result for one cycle with
// done high, in item order, and the receiver cannot stall it. Accepted items wait in a two-entry
// queue in front of the execution unit, so outside the table sweeps busy rises only when that
// queue is full. Push, a pop or top of an empty stack, a put that does nothing and unused
// codes finish in the execute state that follows the idle state fetching the item; a pop, a
// top or a put that acts moves to its own state (BK_POP, BK_TOP or BK_PUT), because the single
// write port of the stack table and the dependent node memory read set the pace. The result is
// registered and shows in the cycle after the unit's last state. After reset and each clear,
// the unit sweeps all min(NUM_STACKS, 1024) stack table entries, one per cycle, with busy high.
module linked_multi_stack_manager_unit #(
	parameter int NUM_STACKS  = 1024,
	parameter int POOL_DEPTH  = 65536,
	parameter int VALUE_WIDTH = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  lmsm_pkg::cmd_t  cmd,
	output logic            done,
	output lmsm_pkg::rsp_t  result
);
	import lmsm_pkg::*;

	q_if_t q;
	logic  deq;
	logic  sweeping;

	lmsm_front #(
		.NUM_STACKS(NUM_STACKS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.cmd      (cmd),
		.busy     (busy),
		.deq      (deq),
		.sweeping (sweeping),
		.q        (q)
	);

	lmsm_back #(
		.NUM_STACKS  (NUM_STACKS),
		.POOL_DEPTH  (POOL_DEPTH),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q        (q),
		.deq      (deq),
		.sweeping (sweeping),
		.done     (done),
		.result   (result)
	);

endmodule

// File: tb/lmsm_result_checker.sv
`timescale 1ns / 1ps

module lmsm_result_checker #(
	parameter int NUM_STACKS = 1024,
	parameter int POOL_DEPTH = 65536
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             busy,
	input  lmsm_pkg::cmd_t   cmd,
	input  logic             done,
	input  lmsm_pkg::rsp_t   result,
	output int               failures,
	output int               outstanding,
	output int               results_checked,
	output int               empty_reports,
	output int               full_reports
);

	import lmsm_pkg::*;

	localparam int PTR_W = $clog2(POOL_DEPTH + 1);
	localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(POOL_DEPTH);

	logic [31:0]      node_val  [POOL_DEPTH];
	logic [PTR_W-1:0] node_next [POOL_DEPTH];
	logic [PTR_W-1:0] head_ptr  [NUM_STACKS];
	logic [PTR_W-1:0] tail_ptr  [NUM_STACKS];
	logic             has_nodes [NUM_STACKS];
	logic [PTR_W-1:0] alloc_ptr;

	rsp_t expected_q[$];

	task automatic empty_all_stacks();
		for (int i = 0; i < NUM_STACKS; i++) begin
			head_ptr[i] = NULL_PTR;
			tail_ptr[i] = NULL_PTR;
			has_nodes[i] = 1'b0;
		end
		alloc_ptr = '0;
	endtask

	// Applies one command to the shadow stacks and returns the response it should give.
	task automatic apply_command(input cmd_t c, output rsp_t r);
		logic [PTR_W-1:0] n;
		int sid;
		int src;
		logic sid_ok;
		logic src_ok;
		r = '0;
		sid = int'(c.stack_id);
		src = int'(c.source_stack);
		sid_ok = sid < NUM_STACKS;
		src_ok = src < NUM_STACKS;
		case (c.operation)
			OP_PUSH: begin
				if (sid_ok) begin
					if (alloc_ptr >= POOL_DEPTH) begin
						r.status = ST_FULL;
					end else begin
						n = alloc_ptr;
						node_val[n] = c.value;
						if (has_nodes[sid]) begin
							node_next[n] = head_ptr[sid];
						end else begin
							node_next[n] = NULL_PTR;
							tail_ptr[sid] = n;
							has_nodes[sid] = 1'b1;
						end
						head_ptr[sid] = n;
						alloc_ptr = n + 1'b1;
					end
				end
			end
			OP_POP: begin
				if (sid_ok && has_nodes[sid] && head_ptr[sid] < POOL_DEPTH) begin
					n = node_next[head_ptr[sid]];
					if (n < POOL_DEPTH) begin
						head_ptr[sid] = n;
					end else begin
						head_ptr[sid] = NULL_PTR;
						tail_ptr[sid] = NULL_PTR;
						has_nodes[sid] = 1'b0;
					end
				end
			end
			OP_TOP: begin
				if (sid_ok && has_nodes[sid] && head_ptr[sid] < POOL_DEPTH) begin
					r.top_value = node_val[head_ptr[sid]];
				end else begin
					r.status = ST_EMPTY;
				end
			end
			OP_PUT: begin
				if (sid_ok && src_ok && sid != src && has_nodes[src]) begin
					if (has_nodes[sid]) begin
						if (tail_ptr[src] < POOL_DEPTH) begin
							node_next[tail_ptr[src]] = head_ptr[sid];
						end
					end else begin
						tail_ptr[sid] = tail_ptr[src];
					end
					head_ptr[sid] = head_ptr[src];
					has_nodes[sid] = 1'b1;
					head_ptr[src] = NULL_PTR;
					tail_ptr[src] = NULL_PTR;
					has_nodes[src] = 1'b0;
				end
			end
			OP_CLEAR: begin
				empty_all_stacks();
			end
			default: begin
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		rsp_t got;
		if (!arst_n) begin
			for (int i = 0; i < POOL_DEPTH; i++) begin
				node_val[i] = '0;
				node_next[i] = '0;
			end
			empty_all_stacks();
			expected_q.delete();
			failures = 0;
			results_checked = 0;
			empty_reports = 0;
			full_reports = 0;
			outstanding <= 0;
		end else begin
			if (done) begin
				got = result;
				if (expected_q.size() == 0) begin
					$error("Result arrived with no item outstanding: top_value %0d, status %0d",
						got.top_value, got.status);
					failures++;
				end else begin
					want = expected_q.pop_front();
					results_checked++;
					if (want.status == ST_EMPTY) empty_reports++;
					if (want.status == ST_FULL) full_reports++;
					if (got.top_value !== want.top_value) begin
						$error("top_value: expected %0d, actual %0d",
							want.top_value, got.top_value);
						failures++;
					end
					if (got.status !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, got.status);
						failures++;
					end
				end
			end
			if (start && !busy) begin
				apply_command(cmd, want);
				expected_q.push_back(want);
			end
			outstanding <= expected_q.size();
		end
	end

endmodule

// File: tb/linked_multi_stack_manager_unit_tb.sv
`timescale 1ns / 1ps

module linked_multi_stack_manager_unit_tb;

	import lmsm_pkg::*;

	localparam int NUM_STACKS  = 1024;
	localparam int POOL_DEPTH  = 65536;
	localparam int STALL_LIMIT = 5000;
	localparam int PHASE_ITEMS = 270;

	localparam logic [2:0] OP_UNUSED_A = 3'd5;
	localparam logic [2:0] OP_UNUSED_B = 3'd6;
	localparam logic [2:0] OP_UNUSED_C = 3'd7;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  start = 1'b0;
	cmd_t  cmd = '0;
	logic  busy;
	logic  done;
	rsp_t  result;

	int failures;
	int outstanding;
	int results_checked;
	int empty_reports;
	int full_reports;
	int items_sent = 0;
	int stall_cycles = 0;

	logic [9:0] hot_ids [8];

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	linked_multi_stack_manager_unit #(
		.NUM_STACKS(NUM_STACKS),
		.POOL_DEPTH(POOL_DEPTH),
		.VALUE_WIDTH(32)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.done(done),
		.result(result)
	);

	lmsm_result_checker #(
		.NUM_STACKS(NUM_STACKS),
		.POOL_DEPTH(POOL_DEPTH)
	) result_check (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.done(done),
		.result(result),
		.failures(failures),
		.outstanding(outstanding),
		.results_checked(results_checked),
		.empty_reports(empty_reports),
		.full_reports(full_reports)
	);

	always @(posedge clk) begin
		if ((start && !busy) || done) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Timed out after %0d cycles with nothing accepted.", stall_cycles);
			$display("linked_multi_stack_manager_unit: mismatch");
			$finish;
		end
	end

	task automatic send(input logic [2:0] op, input logic [9:0] sid, input logic [9:0] src,
			input logic [31:0] val, input int idle_pct);
		cmd_t c;
		c.operation = op;
		c.stack_id = sid;
		c.source_stack = src;
		c.value = val;
		while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		cmd <= c;
		@(posedge clk iff !busy);
		items_sent++;
	endtask

	function automatic logic [9:0] pick_stack();
		if ($urandom_range(7) == 0) return 10'($urandom_range(NUM_STACKS - 1));
		return hot_ids[$urandom_range(7)];
	endfunction

	function automatic logic [31:0] pick_value();
		case ($urandom_range(15))
			0: return 32'hFFFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'h7FFF_FFFF;
			3: return 32'h0;
			default: return $urandom();
		endcase
	endfunction

	task automatic send_random(input int idle_pct);
		int r;
		logic [2:0] op;
		logic [9:0] sid;
		logic [9:0] src;
		r = $urandom_range(99);
		if (r < 38) op = OP_PUSH;
		else if (r < 58) op = OP_POP;
		else if (r < 80) op = OP_TOP;
		else if (r < 93) op = OP_PUT;
		else if (r < 95) op = OP_CLEAR;
		else op = 3'($urandom_range(OP_UNUSED_A, OP_UNUSED_C));
		sid = pick_stack();
		src = ($urandom_range(7) == 0) ? sid : pick_stack();
		send(op, sid, src, pick_value(), idle_pct);
	endtask

	initial begin
		int idle_mix [4];
		idle_mix = '{0, 69, 0, 25};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed checks of the edge cases.
		send(OP_TOP, 10'd0, 10'd0, 32'h0, 0);
		send(OP_PUSH, 10'd0, 10'd1023, 32'h7FFF_FFFF, 0);
		send(OP_PUSH, 10'd0, 10'd0, 32'h8000_0000, 0);
		send(OP_TOP, 10'd0, 10'd0, 32'h0, 0);
		send(OP_PUSH, 10'd1023, 10'd0, 32'hFFFF_FFFF, 0);
		send(OP_TOP, 10'd1023, 10'd0, 32'h0, 0);
		send(OP_POP, 10'd0, 10'd0, 32'hFFFF_FFFF, 0);
		send(OP_TOP, 10'd0, 10'd0, 32'h0, 0);
		send(OP_POP, 10'd0, 10'd0, 32'h0, 0);
		send(OP_POP, 10'd0, 10'd0, 32'h0, 0);
		send(OP_TOP, 10'd0, 10'd0, 32'h0, 0);
		send(OP_PUT, 10'd0, 10'd1023, 32'h0, 0);
		send(OP_PUSH, 10'd5, 10'd0, 32'h0000_0055, 0);
		send(OP_PUT, 10'd5, 10'd5, 32'h0, 0);
		send(OP_PUT, 10'd0, 10'd7, 32'h0, 0);
		send(OP_PUSH, 10'd3, 10'd0, 32'h0, 0);
		send(OP_PUT, 10'd3, 10'd0, 32'h0, 0);
		send(OP_TOP, 10'd3, 10'd0, 32'h0, 0);
		send(OP_POP, 10'd3, 10'd0, 32'h0, 0);
		send(OP_TOP, 10'd3, 10'd0, 32'h0, 0);
		send(OP_UNUSED_A, 10'd3, 10'd0, 32'hFFFF_FFFF, 0);
		send(OP_UNUSED_B, 10'd3, 10'd0, 32'h0, 0);
		send(OP_UNUSED_C, 10'd3, 10'd0, 32'h0, 0);
		send(OP_CLEAR, 10'd0, 10'd0, 32'h0, 0);
		send(OP_TOP, 10'd3, 10'd0, 32'h0, 0);

		// Random traffic on a few busy stacks under each idling mix.
		foreach (idle_mix[p]) begin
			foreach (hot_ids[i]) hot_ids[i] = 10'($urandom_range(NUM_STACKS - 1));
			repeat (PHASE_ITEMS) send_random(idle_mix[p]);
		end

		// A fresh push-heavy burst after a clear, then recovery after another clear.
		send(OP_CLEAR, 10'd0, 10'd0, 32'h0, 0);
		foreach (hot_ids[i]) hot_ids[i] = 10'($urandom_range(NUM_STACKS - 1));
		repeat (24) begin
			send_random(25);
			send(OP_PUSH, pick_stack(), pick_stack(), pick_value(), 25);
		end
		send(OP_CLEAR, 10'd0, 10'd0, 32'h0, 0);
		send(OP_PUSH, 10'd9, 10'd0, 32'h1234_5678, 0);
		send(OP_TOP, 10'd9, 10'd0, 32'h0, 0);
		start <= 1'b0;

		@(posedge clk iff outstanding == 0);
		repeat (16) @(posedge clk);
		$display("Drove %0d items: directed cases, four idling mixes and a push-heavy burst.",
			items_sent);
		$display("Checked %0d results, %0d of them empty tops and %0d dropped pushes.",
			results_checked, empty_reports, full_reports);
		if (failures == 0) begin
			$display("linked_multi_stack_manager_unit: match");
		end else begin
			$display("linked_multi_stack_manager_unit: mismatch");
		end
		$finish;
	end

endmodule
